// File: design/rhtt_pkg.sv
package rhtt_pkg;

    localparam int FIELD_BITS = 12;
    localparam int REQ_BITS   = 2;
    localparam int STAT_BITS  = 2;
    localparam int HELD_BITS  = 5;
    localparam int STEP_BITS  = 4;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_ADD    = 2'd0,
        REQ_SELECT = 2'd1,
        REQ_TAKE   = 2'd2,
        REQ_NONE   = 2'd3
    } req_kind_t;

    typedef enum logic [STAT_BITS-1:0] {
        STAT_OK       = 2'd0,
        STAT_NOTFOUND = 2'd1,
        STAT_FULL     = 2'd2
    } status_t;

    // Datapath action of one microcode step.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_RD_IDX,
        OP_LATCH,
        OP_INC_IDX,
        OP_RD_NEXT,
        OP_WR_SHIFT,
        OP_POP,
        OP_PUSH,
        OP_MISS
    } op_t;

    // Jump condition of one microcode step; when false the step counter advances by one.
    typedef enum logic [2:0] {
        CND_ALWAYS,
        CND_NO_XFER,
        CND_IS_ADD,
        CND_IS_TAKE,
        CND_NOT_SEL,
        CND_IDX_END,
        CND_HIT,
        CND_LAST
    } cond_t;

    typedef struct packed {
        op_t                  op;
        cond_t                cond;
        logic [STEP_BITS-1:0] target;
    } ctl_word_t;

    localparam logic [STEP_BITS-1:0] STEP_WAIT     = 4'd0;
    localparam logic [STEP_BITS-1:0] STEP_DISP_ADD = 4'd1;
    localparam logic [STEP_BITS-1:0] STEP_DISP_TK  = 4'd2;
    localparam logic [STEP_BITS-1:0] STEP_DISP_SEL = 4'd3;
    localparam logic [STEP_BITS-1:0] STEP_SCAN_RD  = 4'd4;
    localparam logic [STEP_BITS-1:0] STEP_SCAN_TST = 4'd5;
    localparam logic [STEP_BITS-1:0] STEP_SCAN_NXT = 4'd6;
    localparam logic [STEP_BITS-1:0] STEP_TAKE_RD  = 4'd7;
    localparam logic [STEP_BITS-1:0] STEP_TAKE_LAT = 4'd8;
    localparam logic [STEP_BITS-1:0] STEP_SHIFT_RD = 4'd9;
    localparam logic [STEP_BITS-1:0] STEP_SHIFT_WR = 4'd10;
    localparam logic [STEP_BITS-1:0] STEP_POP      = 4'd11;
    localparam logic [STEP_BITS-1:0] STEP_ADD      = 4'd12;
    localparam logic [STEP_BITS-1:0] STEP_MISS     = 4'd13;

    function automatic ctl_word_t ctl_rom(input logic [STEP_BITS-1:0] step);
        ctl_word_t w;
        begin
            case (step)
                STEP_WAIT:     w = '{OP_ACCEPT,   CND_NO_XFER, STEP_WAIT};
                STEP_DISP_ADD: w = '{OP_NOP,      CND_IS_ADD,  STEP_ADD};
                STEP_DISP_TK:  w = '{OP_NOP,      CND_IS_TAKE, STEP_TAKE_RD};
                STEP_DISP_SEL: w = '{OP_NOP,      CND_NOT_SEL, STEP_MISS};
                STEP_SCAN_RD:  w = '{OP_RD_IDX,   CND_IDX_END, STEP_MISS};
                STEP_SCAN_TST: w = '{OP_LATCH,    CND_HIT,     STEP_SHIFT_RD};
                STEP_SCAN_NXT: w = '{OP_INC_IDX,  CND_ALWAYS,  STEP_SCAN_RD};
                STEP_TAKE_RD:  w = '{OP_RD_IDX,   CND_IDX_END, STEP_MISS};
                STEP_TAKE_LAT: w = '{OP_LATCH,    CND_ALWAYS,  STEP_SHIFT_RD};
                STEP_SHIFT_RD: w = '{OP_RD_NEXT,  CND_LAST,    STEP_POP};
                STEP_SHIFT_WR: w = '{OP_WR_SHIFT, CND_ALWAYS,  STEP_SHIFT_RD};
                STEP_POP:      w = '{OP_POP,      CND_ALWAYS,  STEP_WAIT};
                STEP_ADD:      w = '{OP_PUSH,     CND_ALWAYS,  STEP_WAIT};
                STEP_MISS:     w = '{OP_MISS,     CND_ALWAYS,  STEP_WAIT};
                default:       w = '{OP_NOP,      CND_ALWAYS,  STEP_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

// File: design/rhtt_req_if.sv
interface rhtt_req_if
    import rhtt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [REQ_BITS-1:0]   req_type;
    logic [FIELD_BITS-1:0] box_x;
    logic [FIELD_BITS-1:0] box_y;
    logic [FIELD_BITS-1:0] box_w;
    logic [FIELD_BITS-1:0] box_h;
    logic [FIELD_BITS-1:0] point_x;
    logic [FIELD_BITS-1:0] point_y;

    modport source (
        output valid, req_type, box_x, box_y, box_w, box_h, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, req_type, box_x, box_y, box_w, box_h, point_x, point_y,
        output ready
    );
endinterface

// File: design/rhtt_rsp_if.sv
interface rhtt_rsp_if
    import rhtt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [STAT_BITS-1:0]  status;
    logic [FIELD_BITS-1:0] hit_x;
    logic [FIELD_BITS-1:0] hit_y;
    logic [FIELD_BITS-1:0] hit_w;
    logic [FIELD_BITS-1:0] hit_h;
    logic [HELD_BITS-1:0]  entries_held;

    modport source (
        output valid, status, hit_x, hit_y, hit_w, hit_h, entries_held,
        input  ready
    );
    modport sink (
        input  valid, status, hit_x, hit_y, hit_w, hit_h, entries_held,
        output ready
    );
endinterface

// File: design/rectangle_hit_test_table_unit.sv
// One request at a time: the next request is taken the cycle after a result is formed.
// A take removes the first box and a select hit the box that holds the point, the boxes
// behind it moving up to close the gap; a take on an empty table or a select without a
// hit is a miss. The single-port box memory is scanned with a read, a test and an advance
// step per entry and compacted with a read and a write step per entry. A finished result
// waits in the output register while the next request is taken. Reset empties the table
// at once.
module rectangle_hit_test_table_unit
    import rhtt_pkg::*;
#(
    parameter int MAX_BOXES  = 16,
    parameter int COORD_BITS = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    rhtt_req_if.sink   req,
    rhtt_rsp_if.source rsp
);

    localparam int CW   = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
    localparam int BW   = 4 * CW;
    localparam int AW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNTW = $clog2(MAX_BOXES + 1);
    localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_BOXES);

    logic [BW-1:0] box_mem [MAX_BOXES];

    logic [STEP_BITS-1:0]  pc_reg, pc_next;
    logic [CNTW-1:0]       count_reg, count_next;
    logic [CNTW-1:0]       idx_reg, idx_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [REQ_BITS-1:0]   kind_reg, kind_next;
    logic [BW-1:0]         box_reg, box_next;
    logic [CW-1:0]         px_reg, px_next;
    logic [CW-1:0]         py_reg, py_next;
    logic [BW-1:0]         hit_reg, hit_next;
    logic [BW-1:0]         rdata_reg;
    logic [STAT_BITS-1:0]  st_reg, st_next;
    logic [BW-1:0]         obox_reg, obox_next;
    logic [CNTW-1:0]       ocnt_reg, ocnt_next;

    ctl_word_t     cw;
    logic          xfer;
    logic          stall;
    logic          cond_true;
    logic          contains;
    logic          last;
    logic [CNTW-1:0] idx_inc;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [BW-1:0] wr_data;
    logic [CW-1:0] rx, ry, rw, rh;

    assign cw      = ctl_rom(pc_reg);
    assign req.ready = (cw.op == OP_ACCEPT);
    assign xfer    = req.valid && req.ready;
    assign stall   = rsp_valid_reg && !rsp.ready &&
                     (cw.op == OP_POP || cw.op == OP_PUSH || cw.op == OP_MISS);
    assign idx_inc = idx_reg + 1'b1;
    assign last    = (idx_inc >= count_reg);

    assign rx = rdata_reg[4*CW-1:3*CW];
    assign ry = rdata_reg[3*CW-1:2*CW];
    assign rw = rdata_reg[2*CW-1:CW];
    assign rh = rdata_reg[CW-1:0];

    // Strict containment; the right and bottom edges are formed one bit wider.
    assign contains = (px_reg > rx) && ({1'b0, px_reg} < ({1'b0, rx} + {1'b0, rw})) &&
                      (py_reg > ry) && ({1'b0, py_reg} < ({1'b0, ry} + {1'b0, rh}));

    always_comb
    begin
        case (cw.cond)
            CND_ALWAYS:  cond_true = 1'b1;
            CND_NO_XFER: cond_true = !xfer;
            CND_IS_ADD:  cond_true = (kind_reg == REQ_ADD);
            CND_IS_TAKE: cond_true = (kind_reg == REQ_TAKE);
            CND_NOT_SEL: cond_true = (kind_reg != REQ_SELECT);
            CND_IDX_END: cond_true = (idx_reg >= count_reg);
            CND_HIT:     cond_true = contains;
            CND_LAST:    cond_true = last;
            default:     cond_true = 1'b1;
        endcase
    end

    always_comb
    begin
        if (stall)
            pc_next = pc_reg;
        else if (cond_true)
            pc_next = cw.target;
        else
            pc_next = pc_reg + 1'b1;
    end

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        kind_next      = kind_reg;
        box_next       = box_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        hit_next       = hit_reg;
        st_next        = st_reg;
        obox_next      = obox_reg;
        ocnt_next      = ocnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = idx_reg[AW-1:0];
        wr_data        = rdata_reg;
        if (!stall)
        begin
            case (cw.op)
                OP_ACCEPT:
                begin
                    if (xfer)
                    begin
                        kind_next = req.req_type;
                        box_next  = {CW'(req.box_x), CW'(req.box_y),
                                     CW'(req.box_w), CW'(req.box_h)};
                        px_next   = CW'(req.point_x);
                        py_next   = CW'(req.point_y);
                        idx_next  = '0;
                    end
                end
                OP_RD_IDX:
                begin
                    rd_en = (idx_reg < count_reg);
                end
                OP_LATCH:
                begin
                    hit_next = rdata_reg;
                end
                OP_INC_IDX:
                begin
                    idx_next = idx_inc;
                end
                OP_RD_NEXT:
                begin
                    rd_en   = !last;
                    rd_addr = idx_inc[AW-1:0];
                end
                OP_WR_SHIFT:
                begin
                    wr_en    = 1'b1;
                    idx_next = idx_inc;
                end
                OP_POP:
                begin
                    count_next     = count_reg - 1'b1;
                    rsp_valid_next = 1'b1;
                    st_next        = STAT_OK;
                    obox_next      = hit_reg;
                    ocnt_next      = count_reg - 1'b1;
                end
                OP_PUSH:
                begin
                    rsp_valid_next = 1'b1;
                    obox_next      = '0;
                    if (count_reg == MAX_CNT)
                    begin
                        st_next   = STAT_FULL;
                        ocnt_next = count_reg;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[AW-1:0];
                        wr_data    = box_reg;
                        count_next = count_reg + 1'b1;
                        st_next    = STAT_OK;
                        ocnt_next  = count_reg + 1'b1;
                    end
                end
                OP_MISS:
                begin
                    rsp_valid_next = 1'b1;
                    st_next        = STAT_NOTFOUND;
                    obox_next      = '0;
                    ocnt_next      = count_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_WAIT;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        kind_reg <= kind_next;
        box_reg  <= box_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        hit_reg  <= hit_next;
        st_reg   <= st_next;
        obox_reg <= obox_next;
        ocnt_reg <= ocnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            box_mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= box_mem[rd_addr];
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = st_reg;
    assign rsp.hit_x        = FIELD_BITS'(obox_reg[4*CW-1:3*CW]);
    assign rsp.hit_y        = FIELD_BITS'(obox_reg[3*CW-1:2*CW]);
    assign rsp.hit_w        = FIELD_BITS'(obox_reg[2*CW-1:CW]);
    assign rsp.hit_h        = FIELD_BITS'(obox_reg[CW-1:0]);
    assign rsp.entries_held = HELD_BITS'(ocnt_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("box count exceeds table size");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_SHIFT_RD || pc_reg == STEP_SHIFT_WR) |-> idx_reg < count_reg)
        else $error("compaction index outside the table");

    a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.op == OP_POP && !stall) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("removal did not shrink the table by one");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && st_reg == STAT_FULL) |-> ocnt_reg == MAX_CNT)
        else $error("full status with room left in the table");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> rsp_valid_reg && $stable(obox_reg))
        else $error("pending result changed before its transfer");

endmodule
